FILE: hdl/hvn_pkg.sv
// ============================================================================
// Value noise package
// Shared types, hash constants and the seed combine function.
// ============================================================================
package hvn_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;

    localparam logic [31:0] MIX_MUL_A = 32'h7feb352d;
    localparam logic [31:0] MIX_MUL_B = 32'h846ca68b;
    localparam logic [31:0] GOLDEN    = 32'h9e3779b9;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic        [31:0] noise_seed;
    } sample_t;

    typedef struct packed {
        logic signed [23:0] noise_value;
        logic signed [23:0] grad_x;
        logic signed [23:0] grad_y;
        logic signed [23:0] grad_z;
    } result_t;

    // Folds a new coordinate into a running hash before it is mixed.
    function automatic logic [31:0] seed_combine(input logic [31:0] a, input logic [31:0] b);
        return a ^ (b + GOLDEN + (a << 6) + (a >> 2));
    endfunction

endpackage

FILE: hdl/hvn_stream_if.sv
// ============================================================================
// Stream channel
// Valid/ready channel carrying one payload per transfer.
// ============================================================================
interface hvn_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

FILE: hdl/hvn_mix.sv
// ============================================================================
// Hash mixer
// Three-stage pipelined xorshift-multiply mixer; a zero result becomes one.
// ============================================================================
module hvn_mix
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] din,
    output logic [31:0] dout
);

    logic [31:0] p1_reg;
    logic [31:0] p2_reg;
    logic [31:0] dout_reg;
    logic [31:0] p1_next;
    logic [31:0] p2_next;
    logic [31:0] dout_next;
    logic [31:0] v3;

    always_comb
    begin
        p1_next   = (din ^ (din >> 16)) * hvn_pkg::MIX_MUL_A;
        p2_next   = (p1_reg ^ (p1_reg >> 15)) * hvn_pkg::MIX_MUL_B;
        v3        = p2_reg ^ (p2_reg >> 16);
        dout_next = (v3 == 32'd0) ? 32'd1 : v3;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

FILE: hdl/hashed_value_noise_3d_gradient_core.sv
// ============================================================================
// 3-D value noise with analytic gradient
// Hashes the eight lattice corners around a point, blends them with
// smoothstep weights and gives the value and its three partial derivatives.
// ============================================================================
// The result is offered from the output register (stage 23) once a point has
// passed through every stage, and it is held there until it is taken.
// Throughput: one point per cycle; the 24 register stages advance together
// and hold as a whole only when the output register is full and not taken.
// Reset clears the stage valid bits only; the datapath registers are not reset.
// ============================================================================
module hashed_value_noise_3d_gradient_core #(
    parameter int FRAC_BITS = hvn_pkg::FRAC_BITS_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    hvn_stream_if.sink   sample,
    hvn_stream_if.source result
);

    localparam int F    = FRAC_BITS;
    localparam int LAST = 23;
    // Blend values stay within a few units, so six integer bits are plenty.
    localparam int WB   = F + 6;
    // Smoothstep weights and slopes are unsigned and below two.
    localparam int SW   = F + 2;
    localparam int PW   = WB + SW + 1;
    localparam int PF   = 2 * F + 4;
    localparam int YW   = F + 25;
    localparam int XW   = WB + 24;

    localparam logic        [PF-1:0] HALF_P     = PF'(1) << (F - 1);
    localparam logic        [PF-1:0] ONE_P      = PF'(1) << F;
    localparam logic signed [PW-1:0] HALF_S     = PW'(1) << (F - 1);
    localparam logic signed [XW-1:0] OUT_MAX_X  = XW'(8388607);
    localparam logic signed [XW-1:0] OUT_MIN_X  = -OUT_MAX_X - XW'(1);
    localparam logic        [YW-1:0] CORNER_RND = YW'(8388607);

    // Signed blend value times an unsigned weight.
    function automatic logic signed [PW-1:0] mul(input logic signed [WB-1:0] a,
                                                 input logic [SW-1:0] w);
        logic signed [PW-1:0] aa;
        logic signed [PW-1:0] ww;
        aa = PW'(a);
        ww = $signed(PW'(w));
        return aa * ww;
    endfunction

    // Drop the fraction bits of a product, rounding half up.
    function automatic logic signed [WB-1:0] rnd(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p + HALF_S;
        return WB'(t >>> F);
    endfunction

    function automatic logic signed [23:0] sat(input logic signed [WB-1:0] v);
        logic signed [XW-1:0] w;
        w = XW'(v);
        if (w > OUT_MAX_X)
        begin
            w = OUT_MAX_X;
        end
        else if (w < OUT_MIN_X)
        begin
            w = OUT_MIN_X;
        end
        return 24'(w);
    endfunction

    // ------------------------------------------------------------------
    // Pipeline control: one enable for every stage.
    // ------------------------------------------------------------------
    logic            adv;
    logic [LAST:0]   vld_reg;

    assign adv          = !vld_reg[LAST] || result.ready;
    assign sample.ready = adv;
    assign result.valid = vld_reg[LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAST-1:0], sample.valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: split the point into cell and fraction, start the x hashes.
    // ------------------------------------------------------------------
    logic [31:0]  cell_x;
    logic [31:0]  cell_y;
    logic [31:0]  cell_z;
    logic [31:0]  pre0_reg [0:1];
    logic [31:0]  cy_pipe_reg [0:3];
    logic [31:0]  cz_pipe_reg [0:7];
    logic [F-1:0] frac_reg [0:2];

    assign cell_x = 32'(sample.data.point_x >>> F);
    assign cell_y = 32'(sample.data.point_y >>> F);
    assign cell_z = 32'(sample.data.point_z >>> F);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pre0_reg[0]    <= hvn_pkg::seed_combine(sample.data.noise_seed, cell_x);
            pre0_reg[1]    <= hvn_pkg::seed_combine(sample.data.noise_seed, cell_x + 32'd1);
            cy_pipe_reg[0] <= cell_y;
            cz_pipe_reg[0] <= cell_z;
            frac_reg[0]    <= sample.data.point_x[F-1:0];
            frac_reg[1]    <= sample.data.point_y[F-1:0];
            frac_reg[2]    <= sample.data.point_z[F-1:0];
            for (int i = 1; i < 4; i++)
            begin
                cy_pipe_reg[i] <= cy_pipe_reg[i-1];
            end
            for (int i = 1; i < 8; i++)
            begin
                cz_pipe_reg[i] <= cz_pipe_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Corner hash chain: x level (stages 1-3), y combine (4) and mix (5-7),
    // z combine (8) and mix (9-11), then the final mix (12-14).
    // Corner index k has x in bit 0, y in bit 1 and z in bit 2.
    // ------------------------------------------------------------------
    logic [31:0] h0 [0:1];
    logic [31:0] h1 [0:3];
    logic [31:0] h2 [0:7];
    logic [31:0] hf [0:7];
    logic [31:0] pre1_reg [0:3];
    logic [31:0] pre2_reg [0:7];

    for (genvar i = 0; i < 2; i++)
    begin : g_mix_x
        hvn_mix u_mix (.clk(clk), .en(adv), .din(pre0_reg[i]), .dout(h0[i]));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 4; j++)
            begin
                pre1_reg[j] <= hvn_pkg::seed_combine(h0[j % 2],
                    cy_pipe_reg[3] + ((j / 2 == 1) ? 32'd1 : 32'd0));
            end
            for (int k = 0; k < 8; k++)
            begin
                pre2_reg[k] <= hvn_pkg::seed_combine(h1[k % 4],
                    cz_pipe_reg[7] + ((k / 4 == 1) ? 32'd1 : 32'd0));
            end
        end
    end

    for (genvar j = 0; j < 4; j++)
    begin : g_mix_y
        hvn_mix u_mix (.clk(clk), .en(adv), .din(pre1_reg[j]), .dout(h1[j]));
    end

    for (genvar k = 0; k < 8; k++)
    begin : g_mix_z
        hvn_mix u_mix_z   (.clk(clk), .en(adv), .din(pre2_reg[k]), .dout(h2[k]));
        hvn_mix u_mix_fin (.clk(clk), .en(adv), .din(h2[k]), .dout(hf[k]));
    end

    // ------------------------------------------------------------------
    // Stages 15-16: corner value = round((2m - D) * ONE / D), D = 2^24 - 1.
    // The quotient by D uses floor(y / D) = (y + (y >> 24) + 1) >> 24,
    // which is exact for y below 2^48 - 1.
    // ------------------------------------------------------------------
    logic [YW-1:0]          y_next [0:7];
    logic                   neg_next [0:7];
    logic [YW-1:0]          y_reg [0:7];
    logic                   neg_reg [0:7];
    logic signed [WB-1:0]   corner_reg [0:7];

    always_comb
    begin
        logic signed [25:0] diff;
        logic signed [25:0] mag;
        for (int k = 0; k < 8; k++)
        begin
            diff        = $signed({1'b0, hf[k][23:0], 1'b0}) - 26'sd16777215;
            mag         = diff[25] ? -diff : diff;
            neg_next[k] = diff[25];
            y_next[k]   = (YW'(mag[23:0]) << F) + CORNER_RND;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [YW-1:0] q;
        if (adv)
        begin
            for (int k = 0; k < 8; k++)
            begin
                y_reg[k]      <= y_next[k];
                neg_reg[k]    <= neg_next[k];
                q             = (y_reg[k] + (y_reg[k] >> 24) + YW'(1)) >> 24;
                corner_reg[k] <= neg_reg[k] ? -$signed(WB'(q)) : $signed(WB'(q));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 1-3: smoothstep weight s and slope d per axis, then a delay
    // line that carries them alongside the corner hashes.
    // ------------------------------------------------------------------
    logic [SW-1:0] tt_reg [0:2];
    logic [PF-1:0] dp_reg [0:2];
    logic [F-1:0]  f1_reg [0:2];
    logic [PF-1:0] sp_reg [0:2];
    logic [SW-1:0] d2_reg [0:2];
    logic [SW-1:0] s_pipe_reg [3:21][0:2];
    logic [SW-1:0] d_pipe_reg [3:21][0:2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tt_reg[i] <= SW'((PF'(frac_reg[i]) * PF'(frac_reg[i]) + HALF_P) >> F);
                dp_reg[i] <= PF'(frac_reg[i]) * (ONE_P - PF'(frac_reg[i]));
                f1_reg[i] <= frac_reg[i];
                sp_reg[i] <= PF'(tt_reg[i])
                             * (ONE_P + ONE_P + ONE_P - (PF'(f1_reg[i]) << 1));
                d2_reg[i] <= SW'(((dp_reg[i] << 2) + (dp_reg[i] << 1) + HALF_P) >> F);
                s_pipe_reg[3][i] <= SW'((sp_reg[i] + HALF_P) >> F);
                d_pipe_reg[3][i] <= d2_reg[i];
                for (int n = 4; n <= 21; n++)
                begin
                    s_pipe_reg[n][i] <= s_pipe_reg[n-1][i];
                    d_pipe_reg[n][i] <= d_pipe_reg[n-1][i];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 17-23: trilinear blend and gradient. In each lane a stage forms
    // one product or finishes a lerp with a rounded add; the last stage clamps.
    // ------------------------------------------------------------------
    logic signed [WB-1:0] e_reg [0:3];
    logic signed [PW-1:0] pa_reg [0:3];
    logic signed [WB-1:0] lo_reg [0:3];
    logic signed [WB-1:0] xv_reg [0:3];
    logic signed [PW-1:0] pe_reg [0:1];
    logic signed [WB-1:0] elo_reg [0:1];
    logic signed [PW-1:0] py_reg [0:1];
    logic signed [WB-1:0] ylo_reg [0:1];
    logic signed [WB-1:0] hx_reg [0:1];
    logic signed [WB-1:0] g_reg [0:1];
    logic signed [WB-1:0] yv_reg [0:1];
    logic signed [PW-1:0] pgx_reg;
    logic signed [WB-1:0] gxlo_reg;
    logic signed [PW-1:0] pgy_reg;
    logic signed [WB-1:0] gylo_reg;
    logic signed [PW-1:0] pv_reg;
    logic signed [WB-1:0] vlo_reg;
    logic signed [WB-1:0] yd_reg;
    logic signed [WB-1:0] gxl_reg;
    logic signed [WB-1:0] gyl_reg;
    logic signed [WB-1:0] val_reg;
    logic signed [PW-1:0] qx_reg;
    logic signed [PW-1:0] qy_reg;
    logic signed [PW-1:0] qz_reg;
    hvn_pkg::result_t     out_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Blend along x; e holds the x differences for the x gradient.
            for (int j = 0; j < 4; j++)
            begin
                e_reg[j]  <= corner_reg[2*j+1] - corner_reg[2*j];
                pa_reg[j] <= mul(corner_reg[2*j+1] - corner_reg[2*j], s_pipe_reg[16][0]);
                lo_reg[j] <= corner_reg[2*j];
                xv_reg[j] <= lo_reg[j] + rnd(pa_reg[j]);
            end
            for (int m = 0; m < 2; m++)
            begin
                // Blend along y, of the values and of the x differences.
                pe_reg[m]  <= mul(e_reg[2*m+1] - e_reg[2*m], s_pipe_reg[17][1]);
                elo_reg[m] <= e_reg[2*m];
                py_reg[m]  <= mul(xv_reg[2*m+1] - xv_reg[2*m], s_pipe_reg[18][1]);
                ylo_reg[m] <= xv_reg[2*m];
                hx_reg[m]  <= xv_reg[2*m+1] - xv_reg[2*m];
                g_reg[m]   <= elo_reg[m] + rnd(pe_reg[m]);
                yv_reg[m]  <= ylo_reg[m] + rnd(py_reg[m]);
            end
            // Blend along z.
            pgx_reg  <= mul(g_reg[1] - g_reg[0], s_pipe_reg[19][2]);
            gxlo_reg <= g_reg[0];
            pgy_reg  <= mul(hx_reg[1] - hx_reg[0], s_pipe_reg[19][2]);
            gylo_reg <= hx_reg[0];
            pv_reg   <= mul(yv_reg[1] - yv_reg[0], s_pipe_reg[20][2]);
            vlo_reg  <= yv_reg[0];
            yd_reg   <= yv_reg[1] - yv_reg[0];
            gxl_reg  <= gxlo_reg + rnd(pgx_reg);
            gyl_reg  <= gylo_reg + rnd(pgy_reg);
            // Scale the differences by the smoothstep slopes.
            val_reg  <= vlo_reg + rnd(pv_reg);
            qx_reg   <= mul(gxl_reg, d_pipe_reg[21][0]);
            qy_reg   <= mul(gyl_reg, d_pipe_reg[21][1]);
            qz_reg   <= mul(yd_reg, d_pipe_reg[21][2]);
            // Output register: round the gradients and clamp all four to the 24-bit result range.
            out_reg.noise_value <= sat(val_reg);
            out_reg.grad_x      <= sat(rnd(qx_reg));
            out_reg.grad_y      <= sat(rnd(qy_reg));
            out_reg.grad_z      <= sat(rnd(qz_reg));
        end
    end

    assign result.data = out_reg;

endmodule

FILE: verif/hvn_noise_scoreboard.sv
`timescale 1ns / 1ps
// ============================================================================
// Value noise scoreboard
// Predicts the noise value and gradient of each accepted sample point and
// compares every delivered result against the oldest prediction.
// ============================================================================
class hvn_noise_scoreboard;

    localparam int F = hvn_pkg::FRAC_BITS_DEFAULT;
    localparam longint ONE = 64'sd1 <<< F;
    localparam longint HALF = 64'sd1 <<< (F - 1);
    localparam longint FULL24 = 64'sd16777215;

    hvn_pkg::result_t pending_results[$];
    int mismatch_count;

    function new();
        mismatch_count = 0;
    endfunction

    function automatic logic [31:0] mix(logic [31:0] v);
        logic [31:0] h;
        h = v ^ (v >> 16);
        h = h * hvn_pkg::MIX_MUL_A;
        h = h ^ (h >> 15);
        h = h * hvn_pkg::MIX_MUL_B;
        h = h ^ (h >> 16);
        return (h == 32'd0) ? 32'd1 : h;
    endfunction

    function automatic logic [31:0] fold(logic [31:0] a, logic [31:0] b);
        logic [31:0] s;
        s = b + hvn_pkg::GOLDEN + (a << 6) + (a >> 2);
        return mix(a ^ s);
    endfunction

    // Round half up when dropping the fraction bits of a product.
    function automatic longint drop_frac(longint x);
        return (x + HALF) >>> F;
    endfunction

    function automatic longint lattice_value(logic [31:0] seed, logic [31:0] x,
                                             logic [31:0] y, logic [31:0] z);
        logic [31:0] h;
        longint m, n, a, q;
        h = fold(fold(fold(seed, x), y), z);
        h = mix(h);
        m = longint'({8'd0, h[23:0]});
        n = (2 * m - FULL24) * ONE;
        a = (n < 0) ? -n : n;
        q = (a + (FULL24 - 1) / 2) / FULL24;
        return (n < 0) ? -q : q;
    endfunction

    function automatic longint blend(longint a, longint b, longint t);
        return a + drop_frac((b - a) * t);
    endfunction

    function automatic logic signed [23:0] clamp24(longint v);
        if (v > 64'sd8388607) v = 64'sd8388607;
        if (v < -64'sd8388608) v = -64'sd8388608;
        return v[23:0];
    endfunction

    function automatic hvn_pkg::result_t predict_noise(hvn_pkg::sample_t s);
        logic [31:0] cl [3];
        logic [31:0] ch [3];
        longint fr [3], ez [3], sl [3];
        longint c [8];
        longint x00, x10, x01, x11, y0v, y1v, v, gx, gy, gz;
        logic [31:0] p [3];
        hvn_pkg::result_t r;
        p[0] = s.point_x; p[1] = s.point_y; p[2] = s.point_z;
        for (int i = 0; i < 3; i++)
        begin
            cl[i] = $signed(p[i]) >>> F;
            ch[i] = cl[i] + 32'd1;
            fr[i] = longint'(p[i][F-1:0]);
            ez[i] = drop_frac(drop_frac(fr[i] * fr[i]) * (3 * ONE - 2 * fr[i]));
            sl[i] = drop_frac(6 * fr[i] * (ONE - fr[i]));
        end
        for (int k = 0; k < 8; k++)
            c[k] = lattice_value(s.noise_seed, k[0] ? ch[0] : cl[0],
                                 k[1] ? ch[1] : cl[1], k[2] ? ch[2] : cl[2]);
        x00 = blend(c[0], c[1], ez[0]);
        x10 = blend(c[2], c[3], ez[0]);
        x01 = blend(c[4], c[5], ez[0]);
        x11 = blend(c[6], c[7], ez[0]);
        y0v = blend(x00, x10, ez[1]);
        y1v = blend(x01, x11, ez[1]);
        v = blend(y0v, y1v, ez[2]);
        gx = drop_frac(blend(blend(c[1] - c[0], c[3] - c[2], ez[1]),
                             blend(c[5] - c[4], c[7] - c[6], ez[1]), ez[2]) * sl[0]);
        gy = drop_frac(blend(x10 - x00, x11 - x01, ez[2]) * sl[1]);
        gz = drop_frac((y1v - y0v) * sl[2]);
        r.noise_value = clamp24(v);
        r.grad_x = clamp24(gx);
        r.grad_y = clamp24(gy);
        r.grad_z = clamp24(gz);
        return r;
    endfunction

    function void note_sample(hvn_pkg::sample_t s);
        pending_results.push_back(predict_noise(s));
    endfunction

    task report_mismatch(string what, logic [23:0] got, logic [23:0] want);
        $display("error: %s got %h expected %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task check_result(hvn_pkg::result_t got);
        hvn_pkg::result_t want;
        if (pending_results.size() == 0)
        begin
            $display("error: result %h arrived with nothing pending", got);
            mismatch_count++;
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.noise_value !== want.noise_value)
                report_mismatch("noise_value", got.noise_value, want.noise_value);
            if (got.grad_x !== want.grad_x) report_mismatch("grad_x", got.grad_x, want.grad_x);
            if (got.grad_y !== want.grad_y) report_mismatch("grad_y", got.grad_y, want.grad_y);
            if (got.grad_z !== want.grad_z) report_mismatch("grad_z", got.grad_z, want.grad_z);
        end
    endtask

endclass

FILE: verif/hashed_value_noise_3d_gradient_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Value noise core testbench
// Streams directed and random sample points through the core with random
// gaps on both channels and checks each result against a local predictor.
// ============================================================================
module hashed_value_noise_3d_gradient_core_tb;

    localparam int RANDOM_POINTS = 1330;
    localparam int PIPE_CYCLES = 24;

    logic clk;
    logic rst_n;
    logic hold_off;

    hvn_stream_if #(.payload_t(hvn_pkg::sample_t)) sample ();
    hvn_stream_if #(.payload_t(hvn_pkg::result_t)) result ();

    hvn_noise_scoreboard noise_board;

    hashed_value_noise_3d_gradient_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample.sink),
        .result (result.source)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Offers one point, waits for its transfer, then idles for a random gap.
    task send_point(input hvn_pkg::sample_t s);
        int gap;
        sample.valid <= 1'b1;
        sample.data <= s;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
        noise_board.note_sample(s);
        gap = $urandom_range(0, 10);
        if (gap != 0)
        begin
            sample.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic hvn_pkg::sample_t random_point();
        hvn_pkg::sample_t s;
        int shape;
        shape = $urandom_range(0, 9);
        s.point_x = $urandom;
        s.point_y = $urandom;
        s.point_z = $urandom;
        s.noise_seed = $urandom;
        // Many points stay near the origin so neighboring cells repeat; some
        // land on lattice points or in the largest and smallest cells.
        if (shape < 4)
        begin
            s.point_x = $signed(s.point_x) >>> 10;
            s.point_y = $signed(s.point_y) >>> 10;
            s.point_z = $signed(s.point_z) >>> 10;
        end
        else if (shape == 4)
        begin
            s.point_x[15:0] = 16'd0;
            s.point_y[15:0] = 16'hffff;
        end
        else if (shape == 5)
        begin
            s.point_x[31:16] = 16'h7fff;
            s.point_z[31:16] = 16'h8000;
        end
        return s;
    endfunction

    // The directed points cover field extremes, lattice points and the wrap
    // of the upper corner at the largest cell.
    task send_directed();
        logic [31:0] edges [6];
        hvn_pkg::sample_t s;
        edges[0] = 32'h0000_0000;
        edges[1] = 32'h7fff_ffff;
        edges[2] = 32'h8000_0000;
        edges[3] = 32'hffff_ffff;
        edges[4] = 32'h0000_8000;
        edges[5] = 32'h0001_0000;
        for (int i = 0; i < 6; i++)
        begin
            s.point_x = edges[i];
            s.point_y = edges[(i + 1) % 6];
            s.point_z = edges[(i + 2) % 6];
            s.noise_seed = (i % 2) ? 32'hffff_ffff : 32'h0;
            send_point(s);
            s.point_x = edges[i];
            s.point_y = edges[i];
            s.point_z = edges[i];
            s.noise_seed = edges[(i + 3) % 6];
            send_point(s);
        end
        s.point_x = 32'h7fff_ffff; s.point_y = 32'h7fff_0000; s.point_z = 32'h7fff_c000;
        s.noise_seed = 32'h1234_5678;
        send_point(s);
    endtask

    // Result side: random stall per result, with one long hold-off once it
    // has been requested.
    initial
    begin
        int stall;
        logic hold_used;
        hold_used = 1'b0;
        result.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off && !hold_used)
            begin
                hold_used = 1'b1;
                result.ready <= 1'b0;
                repeat (200) @(posedge clk);
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (stall != 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
            while (!result.valid)
                @(posedge clk);
            result.ready <= 1'b0;
        end
    end

    // Every result transfer is checked at the clock edge where it happens.
    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
            noise_board.check_result(result.data);
    end

    initial
    begin
        noise_board = new();
        hold_off = 1'b0;
        sample.valid <= 1'b0;
        sample.data <= '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_directed();
        for (int i = 0; i < RANDOM_POINTS; i++)
        begin
            // A long result hold-off fills the pipeline while points keep
            // coming; later the input drains fully before resuming.
            if (i == 100)
                hold_off <= 1'b1;
            if (i == 600)
            begin
                sample.valid <= 1'b0;
                while (noise_board.pending_results.size() != 0)
                    @(posedge clk);
            end
            send_point(random_point());
        end
        sample.valid <= 1'b0;
        while (noise_board.pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES + 10) @(posedge clk);
        if (noise_board.mismatch_count == 0 && noise_board.pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Far beyond the slowest legitimate run.
    initial
    begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
